### hw/rtl/pcc_pkg.sv
// Package for the palette color collector: shared constants, codes and types.
// Used by the channel interfaces, the controller, the datapath and the top level.
package pcc_pkg;

   // Default number of palette slots, slot zero included.
   localparam int PALETTE_SIZE_DEF = 256;

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_PIXEL = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_BLUE  = 2'd2;

   // Reset value of the transparent color.
   localparam logic [7:0] TRANS_RED_RST   = 8'd255;
   localparam logic [7:0] TRANS_GREEN_RST = 8'd0;
   localparam logic [7:0] TRANS_BLUE_RST  = 8'd255;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_PRESENT = 3'd0,
      ST_ADDED   = 3'd1,
      ST_DROPPED = 3'd2,
      ST_SKIPPED = 3'd3,
      ST_READ    = 3'd4,
      ST_CLEARED = 3'd5
   } stat_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RDWAIT,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     capture;
      logic     scan_en;
      logic     add_en;
      logic     clear_en;
      logic     res_load;
      stat_type res_status;
      logic     out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_trans;
      logic match;
      logic exhausted;
      logic full;
      logic out_free;
   } flags_type;

endpackage

### hw/rtl/pcc_if.sv
// Valid/ready channel interfaces of the palette color collector.
// Depends on pcc_pkg for the configuration index width.

// Request channel: one pixel, read or clear request per transaction.
interface pcc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;
   logic [7:0] slot_index;

   modport source (output valid, req_type, pixel_red, pixel_green, pixel_blue, slot_index,
                   input ready);
   modport sink   (input valid, req_type, pixel_red, pixel_green, pixel_blue, slot_index,
                   output ready);
endinterface

// Result channel: one result per transaction.
interface pcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] slot;
   logic [5:0] out_red;
   logic [5:0] out_green;
   logic [5:0] out_blue;
   logic [7:0] used_entries;

   modport source (output valid, status, slot, out_red, out_green, out_blue, used_entries,
                   input ready);
   modport sink   (input valid, status, slot, out_red, out_green, out_blue, used_entries,
                   output ready);
endinterface

// Configuration write channel.
interface pcc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pcc_pkg::CSR_IDX_W-1:0] index;
   logic [7:0]                    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/pcc_ctrl.sv
// Controller state machine of the palette color collector.
// Depends on pcc_pkg for states, request codes and command/status structs.
module pcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_type,
   output logic               req_ready,
   input  pcc_pkg::flags_type flags,
   output pcc_pkg::cmd_type   cmd
);

   pcc_pkg::state_type state_ff, state_in;
   logic               accept;

   // Requests are taken only in the idle state.
   assign accept = req_valid && (state_ff == pcc_pkg::S_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcc_pkg::S_IDLE: begin
            if (accept) begin
               case (req_type)
                  pcc_pkg::REQ_PIXEL: state_in = pcc_pkg::S_SCAN;
                  pcc_pkg::REQ_READ:  state_in = pcc_pkg::S_RDWAIT;
                  pcc_pkg::REQ_CLEAR: state_in = pcc_pkg::S_DONE;
                  default:            state_in = pcc_pkg::S_IDLE;
               endcase
            end
         end
         pcc_pkg::S_SCAN: begin
            if (flags.is_trans || flags.match || flags.exhausted) begin
               state_in = pcc_pkg::S_DONE;
            end
         end
         pcc_pkg::S_RDWAIT: state_in = pcc_pkg::S_DONE;
         pcc_pkg::S_DONE: begin
            if (flags.out_free) begin
               state_in = pcc_pkg::S_IDLE;
            end
         end
         default: state_in = pcc_pkg::S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.res_status = pcc_pkg::ST_PRESENT;
      case (state_ff)
         pcc_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = accept;
            if (accept && req_type == pcc_pkg::REQ_READ) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = pcc_pkg::ST_READ;
            end
            if (accept && req_type == pcc_pkg::REQ_CLEAR) begin
               cmd.clear_en   = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = pcc_pkg::ST_CLEARED;
            end
         end
         pcc_pkg::S_SCAN: begin
            // The search advances only until a decision is made, so the
            // matched slot stays in the compare register.
            if (flags.is_trans) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = pcc_pkg::ST_SKIPPED;
            end else if (flags.match) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = pcc_pkg::ST_PRESENT;
            end else if (flags.exhausted) begin
               cmd.res_load = 1'b1;
               if (flags.full) begin
                  cmd.res_status = pcc_pkg::ST_DROPPED;
               end else begin
                  cmd.add_en     = 1'b1;
                  cmd.res_status = pcc_pkg::ST_ADDED;
               end
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         pcc_pkg::S_RDWAIT: begin
         end
         pcc_pkg::S_DONE: begin
            cmd.out_load = flags.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/pcc_datapath.sv
// Datapath of the palette color collector: color memory, fill count, scan
// pipeline, transparent color registers and result register.
// Depends on pcc_pkg and the channel interfaces in pcc_if.sv.
module pcc_datapath #(
   parameter int PALETTE_SIZE = pcc_pkg::PALETTE_SIZE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         pixel_red,
   input  logic [7:0]         pixel_green,
   input  logic [7:0]         pixel_blue,
   input  logic [7:0]         slot_index,
   input  pcc_pkg::cmd_type   cmd,
   output pcc_pkg::flags_type flags,
   pcc_csr_if.sink            csr_bus,
   pcc_rsp_if.source          rsp_bus
);

   localparam int AW = $clog2(PALETTE_SIZE);
   localparam int SW = (AW > 8) ? AW : 8;

   // Color memory; slot zero is never written.
   logic [23:0]   mem [PALETTE_SIZE];
   logic [AW-1:0] rd_addr;
   logic [23:0]   rd_data_ff;

   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] new_slot;
   logic [AW:0]   z_ff, z_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0] cmp_slot_ff;
   logic          issue;

   logic [23:0]   pix_ff;
   logic [7:0]    idx_ff;
   logic [7:0]    trans_red_ff, trans_green_ff, trans_blue_ff;
   logic [23:0]   trans_color;

   pcc_pkg::stat_type res_status_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]     idx_w, fill_w, slot_w;
   logic              read_hit;
   logic [23:0]       rgb;

   assign trans_color = {trans_red_ff, trans_green_ff, trans_blue_ff};
   assign new_slot    = fill_ff + AW'(1);
   assign idx_w       = SW'(idx_ff);
   assign fill_w      = SW'(fill_ff);

   // Configuration writes are always taken.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_red_ff   <= pcc_pkg::TRANS_RED_RST;
         trans_green_ff <= pcc_pkg::TRANS_GREEN_RST;
         trans_blue_ff  <= pcc_pkg::TRANS_BLUE_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            pcc_pkg::CSR_TRANS_RED:   trans_red_ff   <= csr_bus.data;
            pcc_pkg::CSR_TRANS_GREEN: trans_green_ff <= csr_bus.data;
            pcc_pkg::CSR_TRANS_BLUE:  trans_blue_ff  <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff <= {pixel_red, pixel_green, pixel_blue};
         idx_ff <= slot_index;
      end
   end

   // Scan pipeline: while scanning, issue one slot read per cycle and compare its data in the cycle after.
   assign issue = (z_ff <= {1'b0, fill_ff});

   always_comb begin
      z_in         = z_ff;
      cmp_valid_in = cmp_valid_ff;
      if (cmd.capture) begin
         z_in         = (AW+1)'(1);
         cmp_valid_in = 1'b0;
      end else if (cmd.scan_en) begin
         cmp_valid_in = issue;
         if (issue) begin
            z_in = z_ff + (AW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmp_valid_in;
      end
      z_ff <= z_in;
      if (cmd.scan_en) begin
         cmp_slot_ff <= z_ff[AW-1:0];
      end
   end

   // Memory port: scan address while scanning, otherwise the read slot.
   assign rd_addr = cmd.scan_en ? z_ff[AW-1:0] : idx_w[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.add_en) begin
         mem[new_slot] <= pix_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Fill count.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear_en) begin
         fill_in = '0;
      end else if (cmd.add_en) begin
         fill_in = new_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Status toward the controller.
   assign flags.is_trans  = (pix_ff == trans_color);
   assign flags.match     = cmp_valid_ff && (rd_data_ff == pix_ff);
   assign flags.exhausted = !issue && !cmp_valid_ff;
   assign flags.full      = (fill_ff == AW'(PALETTE_SIZE - 1));
   assign flags.out_free  = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
      end
   end

   // Result fields from the stored status.
   assign read_hit = (idx_w != '0) && (idx_w <= fill_w);

   always_comb begin
      slot_w = '0;
      rgb    = '0;
      case (res_status_ff)
         pcc_pkg::ST_PRESENT: slot_w = SW'(cmp_slot_ff);
         pcc_pkg::ST_ADDED:   slot_w = fill_w;
         pcc_pkg::ST_READ: begin
            slot_w = idx_w;
            rgb    = read_hit ? rd_data_ff : trans_color;
         end
         default: begin
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         rsp_bus.status       <= res_status_ff;
         rsp_bus.slot         <= slot_w[7:0];
         rsp_bus.out_red      <= rgb[23:18];
         rsp_bus.out_green    <= rgb[15:10];
         rsp_bus.out_blue     <= rgb[7:2];
         rsp_bus.used_entries <= fill_w[7:0];
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

endmodule

### hw/rtl/palette_color_collector_unit.sv
// Top level of the palette color collector.
// Depends on pcc_pkg, the interfaces in pcc_if.sv, pcc_ctrl and pcc_datapath.

// The unit collects up to PALETTE_SIZE-1 distinct 24-bit colors from a stream
// of pixel transactions, answers slot reads at 6 bits per channel and empties
// the table on a clear. It works on one request at a time. A pixel that is
// transparent, or sent while the table is empty, is settled without a slot
// read; one found in slot k ends its search there, and one that is added or
// dropped is compared with every filled slot, since the color memory is
// searched through its single read port one slot per cycle. A new request is
// taken while the previous result still waits in the output register. Request
// type 3 is accepted and dropped without a result. Configuration writes are
// accepted in every cycle and must only be issued while the unit is idle.
module palette_color_collector_unit #(
   parameter int PALETTE_SIZE = pcc_pkg::PALETTE_SIZE_DEF
) (
   input logic       clock,
   input logic       reset,
   pcc_req_if.sink   req_bus,
   pcc_rsp_if.source rsp_bus,
   pcc_csr_if.sink   csr_bus
);

   pcc_pkg::cmd_type   cmd;
   pcc_pkg::flags_type flags;

   // Sequencing of each request.
   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Storage, search and result formatting.
   pcc_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .pixel_red   (req_bus.pixel_red),
      .pixel_green (req_bus.pixel_green),
      .pixel_blue  (req_bus.pixel_blue),
      .slot_index  (req_bus.slot_index),
      .cmd         (cmd),
      .flags       (flags),
      .csr_bus     (csr_bus),
      .rsp_bus     (rsp_bus)
   );

endmodule
